// File: rtl/core/cgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared widths and codes for the cell gradient stencil unit.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 5;
  localparam int VAL_W     = 16;
  localparam int CELL_W    = 10;
  localparam int RES_W     = 11;
  localparam int GRAD_W    = 32;
  localparam int CFG_IDX_W = 2;

  // divider: |A| * 2048 over the spacing product
  localparam int NUM_W = 62;
  localparam int DEN_W = 51;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam int NSAMP = 27;
  localparam int NSPC  = 9;

  // function codes
  localparam logic [FUNC_W-1:0] FN_SAMPLE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SPC_X   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SPC_Y   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SPC_Z   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COMPUTE = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RES_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_Z = 2'd2;

  localparam logic [RES_W-1:0] RES_RST = 11'd1024;

endpackage

// File: rtl/core/cgs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_in_if
// Input item channel: loads and compute requests.
// ----------------------------------------------------------------------------
interface cgs_in_if import cgs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [SLOT_W-1:0]        slot;
  logic signed [VAL_W-1:0]  value;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic [CELL_W-1:0]        cell_z;

  modport source (output valid, func, slot, value, cell_x, cell_y, cell_z, input ready);
  modport sink   (input valid, func, slot, value, cell_x, cell_y, cell_z, output ready);
endinterface

// File: rtl/core/cgs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_out_if
// Result channel: cell gradient and overflow flag.
// ----------------------------------------------------------------------------
interface cgs_out_if import cgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [GRAD_W-1:0]  grad_x;
  logic signed [GRAD_W-1:0]  grad_y;
  logic signed [GRAD_W-1:0]  grad_z;
  logic                      overflow;

  modport source (output valid, grad_x, grad_y, grad_z, overflow, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, overflow, output ready);
endinterface

// File: rtl/core/cgs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface cgs_cfg_if import cgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [RES_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cgs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgs_div import cgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// File: rtl/core/cell_gradient_stencil_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_gradient_stencil_unit
// Outward gradient of one cell on a non-uniform grid, Q21.11 saturated.
// ----------------------------------------------------------------------------
// Sample and spacing loads land in two small register-file memories (27
// samples, 9 spacings). A compute transaction then walks the eight corner
// nodes one at a time: clamp the neighbour offsets, fetch 6 spacings and 8
// samples through the single read port of each memory, build the spacing
// product and the three numerators on one shared 35x18 multiplier, and
// divide each numerator by the product on a 62-step restoring divider. The
// time of a compute transaction is set almost entirely by the divider
// running 24 times; input ready is low meanwhile. The result sits in an
// output register, so the next load is taken while it waits. No
// configuration writes should occur while a compute is in flight.
// ----------------------------------------------------------------------------
module cell_gradient_stencil_unit import cgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cgs_in_if.sink     in_ch,
  cgs_out_if.source  out_ch,
  cgs_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_OFFS, S_RD, S_PROD, S_MAC, S_DST, S_DIV, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [RES_W-1:0] res_x_r, res_y_r, res_z_r;

  // sequencer counters
  logic [2:0] node_r;
  logic [1:0] comp_r;
  logic [2:0] sub_r;
  logic [3:0] cnt_r;

  logic [CELL_W-1:0] cx_r, cy_r, cz_r;

  // clamped offsets: index 0 x, 1 y, 2 z
  logic [1:0] lo_r [3];
  logic [1:0] hi_r [3];

  // fetched operands: spacings xm,xp,ym,yp,zm,zp and corner samples f0..f7
  logic [VAL_W-1:0]        sp_r [6];
  logic signed [VAL_W-1:0] f_r  [8];

  // datapath
  logic signed [52:0] prod_r;
  logic signed [52:0] acc_r;
  logic signed [34:0] d1_r, d2_r;
  logic signed [52:0] a_r;
  logic [DEN_W-1:0]   p_r;
  logic signed [44:0] gacc_r [3];
  logic               ovf_r;

  // output register
  logic                     out_vld_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gz_r;
  logic                     oflow_r;

  // memories
  logic [VAL_W-1:0] samp_mem [NSAMP];
  logic [VAL_W-1:0] spc_mem  [NSPC];
  logic [VAL_W-1:0] samp_rd_r, spc_rd_r;
  logic [4:0]       samp_ra, samp_wa;
  logic [3:0]       spc_ra, spc_wa;

  logic in_acc, cfg_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // --------------------------------------------------------------------------
  // offset clamp for one axis
  // --------------------------------------------------------------------------
  function automatic logic [3:0] axis_off(input logic [CELL_W-1:0] c, input logic n,
                                          input logic [RES_W-1:0] r);
    logic signed [12:0] cs, m, p, top, dl, dh;
    logic [1:0] lo, hi;
    cs  = $signed({3'b0, c});
    m   = cs + $signed({12'b0, n}) - 13'sd1;
    p   = cs + $signed({12'b0, n});
    top = $signed({2'b0, r}) - 13'sd1;
    if (m < 13'sd0) m = 13'sd0;
    if (p > top) p = top;
    dl = m - cs + 13'sd1;
    dh = p - cs + 13'sd1;
    lo = (dl < 13'sd0) ? 2'd0 : ((dl > 13'sd2) ? 2'd2 : dl[1:0]);
    hi = (dh < 13'sd0) ? 2'd0 : ((dh > 13'sd2) ? 2'd2 : dh[1:0]);
    return {lo, hi};
  endfunction

  function automatic logic signed [16:0] diff17(input logic signed [VAL_W-1:0] a,
                                                input logic signed [VAL_W-1:0] b);
    return $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
  endfunction

  // negate, divide by 8 toward zero, saturate; msb is the saturation flag
  function automatic logic [GRAD_W:0] finish_f(input logic signed [44:0] acc);
    logic signed [45:0] ng, adj;
    logic [42:0] r;
    logic sat;
    ng  = -$signed({acc[44], acc});
    adj = ng[45] ? (ng + 46'sd7) : ng;
    r   = adj[45:3];
    sat = !((&r[42:31]) || !(|r[42:31]));
    if (sat) return {1'b1, r[42] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    return {1'b0, r[31:0]};
  endfunction

  logic [3:0] offx, offy, offz;
  assign offx = axis_off(cx_r, node_r[0], res_x_r);
  assign offy = axis_off(cy_r, node_r[1], res_y_r);
  assign offz = axis_off(cz_r, node_r[2], res_z_r);

  // --------------------------------------------------------------------------
  // read addresses for the fetch walk
  // --------------------------------------------------------------------------
  logic [3:0] qi;
  logic [2:0] q;
  logic [1:0] sx_o, sy_o, sz_o;
  assign qi   = cnt_r - 4'd6;
  assign q    = qi[2:0];
  assign sx_o = q[0] ? hi_r[0] : lo_r[0];
  assign sy_o = q[1] ? hi_r[1] : lo_r[1];
  assign sz_o = q[2] ? hi_r[2] : lo_r[2];
  assign samp_ra = 5'(sx_o) + 5'(sy_o) * 5'd3 + 5'(sz_o) * 5'd9;

  always_comb begin
    unique case (cnt_r)
      4'd0:    spc_ra = 4'(lo_r[0]);
      4'd1:    spc_ra = 4'(hi_r[0]);
      4'd2:    spc_ra = 4'd3 + 4'(lo_r[1]);
      4'd3:    spc_ra = 4'd3 + 4'(hi_r[1]);
      4'd4:    spc_ra = 4'd6 + 4'(lo_r[2]);
      4'd5:    spc_ra = 4'd6 + 4'(hi_r[2]);
      default: spc_ra = 4'd0;
    endcase
  end

  // write addresses
  assign samp_wa = in_ch.slot;
  always_comb begin
    unique case (in_ch.func)
      FN_SPC_Y: spc_wa = 4'd3 + 4'(in_ch.slot[1:0]);
      FN_SPC_Z: spc_wa = 4'd6 + 4'(in_ch.slot[1:0]);
      default:  spc_wa = 4'(in_ch.slot[1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.func == FN_SAMPLE && in_ch.slot < SLOT_W'(NSAMP))
      samp_mem[samp_wa] <= in_ch.value;
    samp_rd_r <= samp_mem[samp_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.func == FN_SPC_X || in_ch.func == FN_SPC_Y ||
                   in_ch.func == FN_SPC_Z) && in_ch.slot < SLOT_W'(3))
      spc_mem[spc_wa] <= in_ch.value;
    spc_rd_r <= spc_mem[spc_ra];
  end

  // --------------------------------------------------------------------------
  // shared multiplier operand select
  // --------------------------------------------------------------------------
  logic [16:0] sum_x, sum_y, sum_z;
  assign sum_x = {1'b0, sp_r[0]} + {1'b0, sp_r[1]};
  assign sum_y = {1'b0, sp_r[2]} + {1'b0, sp_r[3]};
  assign sum_z = {1'b0, sp_r[4]} + {1'b0, sp_r[5]};

  logic signed [16:0] e0, e1, e2, e3;
  logic [VAL_W-1:0]   s_m, s_p, t_m, t_p;
  always_comb begin
    unique case (comp_r)
      2'd0: begin
        e0 = diff17(f_r[7], f_r[6]); e1 = diff17(f_r[3], f_r[2]);
        e2 = diff17(f_r[5], f_r[4]); e3 = diff17(f_r[1], f_r[0]);
        s_m = sp_r[4]; s_p = sp_r[5]; t_m = sp_r[2]; t_p = sp_r[3];
      end
      2'd1: begin
        e0 = diff17(f_r[7], f_r[5]); e1 = diff17(f_r[3], f_r[1]);
        e2 = diff17(f_r[6], f_r[4]); e3 = diff17(f_r[2], f_r[0]);
        s_m = sp_r[4]; s_p = sp_r[5]; t_m = sp_r[0]; t_p = sp_r[1];
      end
      default: begin
        e0 = diff17(f_r[7], f_r[3]); e1 = diff17(f_r[5], f_r[1]);
        e2 = diff17(f_r[6], f_r[2]); e3 = diff17(f_r[4], f_r[0]);
        s_m = sp_r[2]; s_p = sp_r[3]; t_m = sp_r[0]; t_p = sp_r[1];
      end
    endcase
  end

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PROD) begin
      if (sub_r == 3'd0) begin
        mul_a = $signed({18'b0, sum_x});
        mul_b = $signed({1'b0, sum_y});
      end else begin
        mul_a = $signed({1'b0, prod_r[33:0]});
        mul_b = $signed({1'b0, sum_z});
      end
    end else if (state_r == S_MAC) begin
      unique case (sub_r)
        3'd0:    begin mul_a = 35'(e0); mul_b = $signed({2'b0, s_m}); end
        3'd1:    begin mul_a = 35'(e1); mul_b = $signed({2'b0, s_p}); end
        3'd2:    begin mul_a = 35'(e2); mul_b = $signed({2'b0, s_m}); end
        3'd3:    begin mul_a = 35'(e3); mul_b = $signed({2'b0, s_p}); end
        3'd4:    begin mul_a = d1_r;    mul_b = $signed({2'b0, t_m}); end
        3'd5:    begin mul_a = d2_r;    mul_b = $signed({2'b0, t_p}); end
        default: begin mul_a = '0;      mul_b = '0; end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // divider and node quotient clamp to +-2^40
  // --------------------------------------------------------------------------
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [52:0]        a_mag;
  logic               q_big;
  logic [40:0]        q_mag;
  logic signed [44:0] q_s;

  assign a_mag     = a_r[52] ? 53'(-a_r) : 53'(a_r);
  assign div_start = (state_r == S_DST) && (p_r != '0);

  cgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({a_mag[50:0], 11'b0}),
    .den   (p_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_big = (|div_quot[NUM_W-1:41]) || (div_quot[40] && (|div_quot[39:0]));
  assign q_mag = q_big ? {1'b1, 40'b0} : div_quot[40:0];
  assign q_s   = a_r[52] ? -$signed({4'b0, q_mag}) : $signed({4'b0, q_mag});

  logic [GRAD_W:0] fin_x, fin_y, fin_z;
  assign fin_x = finish_f(gacc_r[0]);
  assign fin_y = finish_f(gacc_r[1]);
  assign fin_z = finish_f(gacc_r[2]);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic [3:0] cap_i;
  logic [3:0] cap_f;
  assign cap_i = cnt_r - 4'd1;
  assign cap_f = cnt_r - 4'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_x_r   <= RES_RST;
      res_y_r   <= RES_RST;
      res_z_r   <= RES_RST;
      out_vld_r <= 1'b0;
      node_r    <= '0;
      comp_r    <= '0;
      sub_r     <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          CFG_RES_X: res_x_r <= cfg_ch.data;
          CFG_RES_Y: res_y_r <= cfg_ch.data;
          CFG_RES_Z: res_z_r <= cfg_ch.data;
          default: ;
        endcase
      end
      // the final state loads the output register itself
      if (out_vld_r && out_ch.ready && state_r != S_FIN) out_vld_r <= 1'b0;

      prod_r <= mul_a * mul_b;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.func == FN_COMPUTE) begin
            cx_r      <= in_ch.cell_x;
            cy_r      <= in_ch.cell_y;
            cz_r      <= in_ch.cell_z;
            node_r    <= '0;
            ovf_r     <= 1'b0;
            gacc_r[0] <= '0;
            gacc_r[1] <= '0;
            gacc_r[2] <= '0;
            state_r   <= S_OFFS;
          end
        end
        S_OFFS: begin
          lo_r[0] <= offx[3:2]; hi_r[0] <= offx[1:0];
          lo_r[1] <= offy[3:2]; hi_r[1] <= offy[1:0];
          lo_r[2] <= offz[3:2]; hi_r[2] <= offz[1:0];
          cnt_r   <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          // read data of the previous address arrives this cycle
          if (cnt_r != 4'd0) begin
            if (cap_i < 4'd6) sp_r[cap_i[2:0]] <= spc_rd_r;
            else              f_r[cap_f[2:0]]  <= samp_rd_r;
          end
          if (cnt_r == 4'd14) begin
            sub_r   <= '0;
            state_r <= S_PROD;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_PROD: begin
          if (sub_r == 3'd2) begin
            p_r     <= prod_r[DEN_W-1:0];
            comp_r  <= '0;
            sub_r   <= '0;
            state_r <= S_MAC;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_MAC: begin
          // products land in the cycle after issue
          unique case (sub_r)
            3'd1, 3'd3, 3'd5: acc_r <= prod_r;
            3'd2:    d1_r <= 35'(acc_r + prod_r);
            3'd4:    d2_r <= 35'(acc_r + prod_r);
            3'd6:    a_r  <= acc_r + prod_r;
            default: ;
          endcase
          if (sub_r == 3'd6) state_r <= S_DST;
          else               sub_r   <= sub_r + 3'd1;
        end
        S_DST: begin
          if (p_r == '0) begin
            // zero spacing product: node adds nothing
            ovf_r <= 1'b1;
            if (comp_r != 2'd2) begin
              comp_r  <= comp_r + 2'd1;
              sub_r   <= '0;
              state_r <= S_MAC;
            end else if (node_r != 3'd7) begin
              node_r  <= node_r + 3'd1;
              state_r <= S_OFFS;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (q_big) ovf_r <= 1'b1;
            unique case (comp_r)
              2'd0:    gacc_r[0] <= gacc_r[0] + q_s;
              2'd1:    gacc_r[1] <= gacc_r[1] + q_s;
              default: gacc_r[2] <= gacc_r[2] + q_s;
            endcase
            if (comp_r != 2'd2) begin
              comp_r  <= comp_r + 2'd1;
              sub_r   <= '0;
              state_r <= S_MAC;
            end else if (node_r != 3'd7) begin
              node_r  <= node_r + 3'd1;
              state_r <= S_OFFS;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_vld_r || out_ch.ready) begin
            gx_r      <= fin_x[GRAD_W-1:0];
            gy_r      <= fin_y[GRAD_W-1:0];
            gz_r      <= fin_z[GRAD_W-1:0];
            oflow_r   <= ovf_r || fin_x[GRAD_W] || fin_y[GRAD_W] || fin_z[GRAD_W];
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.grad_x   = gx_r;
  assign out_ch.grad_y   = gy_r;
  assign out_ch.grad_z   = gz_r;
  assign out_ch.overflow = oflow_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> cnt_r <= 4'd14)
    else $error("fetch counter ran past the last operand");

  a_result_after_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_FIN && $past(node_r) == 3'd7)
    else $error("result raised before all eight nodes were done");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC || state_r == S_DIV) |-> comp_r != 2'd3)
    else $error("component counter out of range");

endmodule
